>>> hdl/opu_pkg.sv
package opu_pkg;

   localparam int DW        = 32;
   localparam int FB        = 24;
   localparam int SW        = DW - 1;
   localparam int COEF_W    = FB + 1;
   localparam int CORR_W    = 31;
   localparam int CSR_W     = 31;
   localparam int CSR_IDX_W = 3;
   localparam int MODE_W    = 3;
   localparam int SV_W      = 41;
   localparam int MAG_W     = 39;
   localparam int ROOT_W    = 28;
   localparam int REM_W     = ROOT_W + 3;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int QUO_W     = DW + FB;
   localparam int DEN_W     = ROOT_W + 1;
   localparam int QC_W      = DW + 2;

   typedef logic signed [SV_W-1:0] sval_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_SGD      = 3'd0,
      MODE_MOMENTUM = 3'd1,
      MODE_ADAGRAD  = 3'd2,
      MODE_RMSPROP  = 3'd3,
      MODE_ADAM     = 3'd4
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MODE         = 3'd0,
      REG_LEARN_RATE   = 3'd1,
      REG_DECAY_FIRST  = 3'd2,
      REG_DECAY_SECOND = 3'd3,
      REG_EPSILON      = 3'd4,
      REG_FIRST_CORR   = 3'd5,
      REG_SECOND_CORR  = 3'd6
   } reg_index_type;

   localparam logic [COEF_W-1:0] FX_ONE     = COEF_W'(1) << FB;
   localparam logic [COEF_W-1:0] LR_RESET   = COEF_W'(167772);
   localparam logic [CORR_W-1:0] CORR_RESET = CORR_W'(1) << FB;
   localparam sval_type SMAX = $signed(SV_W'((64'd1 << (DW - 1)) - 64'd1));
   localparam sval_type SMIN = ~SMAX;
   localparam logic [QC_W-1:0] QC_MAX = QC_W'(1) << (QC_W - 1);

   function automatic logic [DW-1:0] mag32(input logic signed [DW-1:0] a);
      logic [DW-1:0] r;
      r = a[DW-1] ? DW'(-a) : DW'(a);
      return r;
   endfunction

   // rounded product, half away from zero
   function automatic sval_type fx_mul(input logic [MAG_W-1:0] am, input logic [DW-1:0] bm,
                                       input logic neg);
      logic [MAG_W+DW-1:0] prod;
      logic [MAG_W+DW-1:0] rnd;
      sval_type mag;
      prod = am * bm;
      rnd  = (prod + ((MAG_W + DW)'(1) << (FB - 1))) >> FB;
      mag  = $signed(SV_W'(rnd[SV_W-2:0]));
      return neg ? -mag : mag;
   endfunction

   function automatic logic signed [DW-1:0] sat_s(input sval_type x);
      logic signed [DW-1:0] r;
      if (x > SMAX) begin
         r = SMAX[DW-1:0];
      end else if (x < SMIN) begin
         r = SMIN[DW-1:0];
      end else begin
         r = x[DW-1:0];
      end
      return r;
   endfunction

   function automatic logic [SW-1:0] sat_u(input sval_type x);
      logic [SW-1:0] r;
      if (x > SMAX) begin
         r = SMAX[SW-1:0];
      end else if (x < 0) begin
         r = '0;
      end else begin
         r = x[SW-1:0];
      end
      return r;
   endfunction

endpackage

>>> hdl/opu_root.sv
module opu_root #(
   parameter int SIDE_W = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_vld,
   input  logic [opu_pkg::SW-1:0]      in_value,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_vld,
   output logic [opu_pkg::ROOT_W-1:0]  out_root,
   output logic [SIDE_W-1:0]           out_side
);
   import opu_pkg::*;

   localparam int N = ROOT_W;

   logic              vld_ff  [N];
   logic              vld_in  [N];
   logic [REM_W-1:0]  rem_ff  [N];
   logic [REM_W-1:0]  rem_in  [N];
   logic [ROOT_W-1:0] rt_ff   [N];
   logic [ROOT_W-1:0] rt_in   [N];
   logic [RAD_W-1:0]  rad_ff  [N];
   logic [RAD_W-1:0]  rad_in  [N];
   logic [SIDE_W-1:0] side_ff [N];
   logic [SIDE_W-1:0] side_in [N];

   // one root bit per stage, two radicand bits consumed
   always_comb begin
      logic [REM_W-1:0]  prem;
      logic [ROOT_W-1:0] prt;
      logic [RAD_W-1:0]  prad;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic              take;
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            vld_in[k]  = in_vld;
            side_in[k] = in_side;
            prem       = '0;
            prt        = '0;
            prad       = RAD_W'({in_value, {FB{1'b0}}});
         end else begin
            vld_in[k]  = vld_ff[k-1];
            side_in[k] = side_ff[k-1];
            prem       = rem_ff[k-1];
            prt        = rt_ff[k-1];
            prad       = rad_ff[k-1];
         end
         rem_sh    = {prem[REM_W-3:0], prad[RAD_W-1 -: 2]};
         trial     = REM_W'({prt, 2'b01});
         take      = (rem_sh >= trial);
         rem_in[k] = take ? (rem_sh - trial) : rem_sh;
         rt_in[k]  = {prt[ROOT_W-2:0], take};
         rad_in[k] = {prad[RAD_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            rem_ff[k]  <= rem_in[k];
            rt_ff[k]   <= rt_in[k];
            rad_ff[k]  <= rad_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign out_vld  = vld_ff[N-1];
   assign out_root = rt_ff[N-1];
   assign out_side = side_ff[N-1];

endmodule

>>> hdl/opu_div.sv
module opu_div #(
   parameter int SIDE_W = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_vld,
   input  logic [opu_pkg::QUO_W-1:0]  in_dividend,
   input  logic [opu_pkg::DEN_W-1:0]  in_divisor,
   input  logic [SIDE_W-1:0]          in_side,
   output logic                       out_vld,
   output logic [opu_pkg::QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0]          out_side
);
   import opu_pkg::*;

   localparam int N = QUO_W;

   logic              vld_ff  [N];
   logic              vld_in  [N];
   logic [DEN_W-1:0]  rem_ff  [N];
   logic [DEN_W-1:0]  rem_in  [N];
   logic [QUO_W-1:0]  dq_ff   [N];
   logic [QUO_W-1:0]  dq_in   [N];
   logic [DEN_W-1:0]  den_ff  [N];
   logic [DEN_W-1:0]  den_in  [N];
   logic [SIDE_W-1:0] side_ff [N];
   logic [SIDE_W-1:0] side_in [N];

   // restoring division, one quotient bit per stage
   always_comb begin
      logic [DEN_W-1:0] prem;
      logic [QUO_W-1:0] pdq;
      logic [DEN_W:0]   rem_sh;
      logic             take;
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            vld_in[k]  = in_vld;
            side_in[k] = in_side;
            den_in[k]  = in_divisor;
            prem       = '0;
            pdq        = in_dividend;
         end else begin
            vld_in[k]  = vld_ff[k-1];
            side_in[k] = side_ff[k-1];
            den_in[k]  = den_ff[k-1];
            prem       = rem_ff[k-1];
            pdq        = dq_ff[k-1];
         end
         rem_sh    = {prem, pdq[QUO_W-1]};
         take      = (rem_sh >= {1'b0, den_in[k]});
         rem_in[k] = take ? DEN_W'(rem_sh - {1'b0, den_in[k]}) : DEN_W'(rem_sh);
         dq_in[k]  = {pdq[QUO_W-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            rem_ff[k]  <= rem_in[k];
            dq_ff[k]   <= dq_in[k];
            den_ff[k]  <= den_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign out_vld  = vld_ff[N-1];
   assign out_quo  = dq_ff[N-1];
   assign out_side = side_ff[N-1];

endmodule

>>> hdl/optimizer_param_update.sv
// pipeline from accepted request to response: 5 arithmetic stages,
// 28 square-root stages, 56 divider stages, 1 output register
// throughput: one transaction per cycle; a stalled response freezes the whole pipe
// reset: synchronous, active high; clears all valid bits and loads register defaults
module optimizer_param_update (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [opu_pkg::DW-1:0]     req_param_value,
   input  logic signed [opu_pkg::DW-1:0]     req_grad_value,
   input  logic signed [opu_pkg::DW-1:0]     req_first_moment,
   input  logic [opu_pkg::SW-1:0]            req_second_moment,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [opu_pkg::DW-1:0]     rsp_new_param,
   output logic signed [opu_pkg::DW-1:0]     rsp_new_first_moment,
   output logic [opu_pkg::SW-1:0]            rsp_new_second_moment,
   output logic                              rsp_coef_error,
   input  logic                              csr_write,
   input  logic [opu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [opu_pkg::CSR_W-1:0]         csr_data
);
   import opu_pkg::*;

   localparam int ROOT_SIDE_W = 4 * DW + SW;
   localparam int DIV_SIDE_W  = 3 * DW + SW + 1;

   logic [MODE_W-1:0] mode_ff;
   logic [COEF_W-1:0] lr_ff;
   logic [COEF_W-1:0] d1_ff;
   logic [COEF_W-1:0] d2_ff;
   logic [COEF_W-1:0] eps_ff;
   logic [CORR_W-1:0] c1_ff;
   logic [CORR_W-1:0] c2_ff;

   logic [COEF_W-1:0] d1c, d2c, om1, om2;
   logic              err;
   logic              adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SGD;
         lr_ff   <= LR_RESET;
         d1_ff   <= '0;
         d2_ff   <= '0;
         eps_ff  <= '0;
         c1_ff   <= CORR_RESET;
         c2_ff   <= CORR_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MODE:         mode_ff <= csr_data[MODE_W-1:0];
            REG_LEARN_RATE:   lr_ff   <= csr_data[COEF_W-1:0];
            REG_DECAY_FIRST:  d1_ff   <= csr_data[COEF_W-1:0];
            REG_DECAY_SECOND: d2_ff   <= csr_data[COEF_W-1:0];
            REG_EPSILON:      eps_ff  <= csr_data[COEF_W-1:0];
            REG_FIRST_CORR:   c1_ff   <= csr_data[CORR_W-1:0];
            REG_SECOND_CORR:  c2_ff   <= csr_data[CORR_W-1:0];
            default: ;
         endcase
      end
   end

   assign d1c = (d1_ff > FX_ONE) ? FX_ONE : d1_ff;
   assign d2c = (d2_ff > FX_ONE) ? FX_ONE : d2_ff;
   assign om1 = FX_ONE - d1c;
   assign om2 = FX_ONE - d2c;

   always_comb begin
      unique case (mode_ff)
         MODE_SGD:      err = 1'b0;
         MODE_MOMENTUM: err = (d1_ff == '0);
         MODE_ADAGRAD:  err = (eps_ff == '0);
         MODE_RMSPROP:  err = (d1_ff == '0) || (eps_ff == '0);
         MODE_ADAM:     err = (d1_ff == '0) || (d2_ff == '0) || (eps_ff == '0);
         default:       err = 1'b1;
      endcase
   end

   assign req_stall = rsp_valid && rsp_stall;
   assign adv       = !req_stall;

   // stage 1: products of the inputs
   logic                 s1_vld_ff;
   logic signed [DW-1:0] s1_p_ff, s1_m_ff;
   logic [SW-1:0]        s1_s_ff;
   sval_type             s1_a_ff, s1_b_ff, s1_c_ff, s1_d_ff;
   sval_type             s1_a_in, s1_b_in, s1_c_in, s1_d_in, gsq_full;
   logic [MAG_W-1:0]     s1_gsq_ff;
   logic [DW-1:0]        g_mag, m_mag;

   always_comb begin
      g_mag    = mag32(req_grad_value);
      m_mag    = mag32(req_first_moment);
      s1_a_in  = (mode_ff == MODE_RMSPROP) ?
                 fx_mul(MAG_W'(d1c), DW'(req_second_moment), 1'b0) :
                 fx_mul(MAG_W'(d1c), m_mag, req_first_moment[DW-1]);
      s1_b_in  = fx_mul(MAG_W'(lr_ff), g_mag, req_grad_value[DW-1]);
      s1_c_in  = fx_mul(MAG_W'(om1), g_mag, req_grad_value[DW-1]);
      s1_d_in  = fx_mul(MAG_W'(d2c), DW'(req_second_moment), 1'b0);
      gsq_full = fx_mul(MAG_W'(g_mag), g_mag, 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_p_ff   <= req_param_value;
         s1_m_ff   <= req_first_moment;
         s1_s_ff   <= req_second_moment;
         s1_a_ff   <= s1_a_in;
         s1_b_ff   <= s1_b_in;
         s1_c_ff   <= s1_c_in;
         s1_d_ff   <= s1_d_in;
         s1_gsq_ff <= gsq_full[MAG_W-1:0];
      end
   end

   // stage 2: sums, second gradient product
   logic                 s2_vld_ff;
   logic signed [DW-1:0] s2_p_ff, s2_nm_ff, s2_np_ff, s2_num_ff;
   logic [SW-1:0]        s2_s_ff, s2_nsada_ff;
   sval_type             s2_e_ff, s2_sadd_ff, s2_e_in;
   logic signed [DW-1:0] s2_nm_in, s2_np_in, mom_sum;
   logic [COEF_W-1:0]    kq;
   sval_type             p41;

   always_comb begin
      kq       = (mode_ff == MODE_ADAM) ? om2 : om1;
      s2_e_in  = fx_mul(s1_gsq_ff, DW'(kq), 1'b0);
      mom_sum  = sat_s(s1_a_ff + s1_b_ff);
      p41      = SV_W'(s1_p_ff);
      s2_nm_in = s1_m_ff;
      s2_np_in = s1_p_ff;
      case (mode_ff)
         MODE_SGD: begin
            s2_np_in = sat_s(p41 - s1_b_ff);
         end
         MODE_MOMENTUM: begin
            s2_nm_in = mom_sum;
            s2_np_in = sat_s(p41 - SV_W'(mom_sum));
         end
         MODE_ADAM: begin
            s2_nm_in = sat_s(s1_a_ff + s1_c_ff);
         end
         default: ;
      endcase
      if (err) begin
         s2_nm_in = s1_m_ff;
         s2_np_in = s1_p_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_p_ff     <= s1_p_ff;
         s2_s_ff     <= s1_s_ff;
         s2_e_ff     <= s2_e_in;
         s2_sadd_ff  <= (mode_ff == MODE_RMSPROP) ? s1_a_ff : s1_d_ff;
         s2_nm_ff    <= s2_nm_in;
         s2_np_ff    <= s2_np_in;
         s2_nsada_ff <= sat_u($signed(SV_W'(s1_s_ff) + SV_W'(s1_gsq_ff)));
         s2_num_ff   <= sat_s(s1_b_ff);
      end
   end

   // stage 3: second moment, bias-corrected first moment product
   logic                 s3_vld_ff;
   logic signed [DW-1:0] s3_p_ff, s3_nm_ff, s3_np_ff, s3_num_ff;
   logic [SW-1:0]        s3_ns_ff, s3_ns_in;
   sval_type             s3_mh_ff, s3_mh_in;

   always_comb begin
      case (mode_ff)
         MODE_ADAGRAD:            s3_ns_in = s2_nsada_ff;
         MODE_RMSPROP, MODE_ADAM: s3_ns_in = sat_u(s2_sadd_ff + s2_e_ff);
         default:                 s3_ns_in = s2_s_ff;
      endcase
      if (err) begin
         s3_ns_in = s2_s_ff;
      end
      s3_mh_in = fx_mul(MAG_W'(mag32(s2_nm_ff)), DW'(c1_ff), s2_nm_ff[DW-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_p_ff   <= s2_p_ff;
         s3_nm_ff  <= s2_nm_ff;
         s3_np_ff  <= s2_np_ff;
         s3_num_ff <= s2_num_ff;
         s3_ns_ff  <= s3_ns_in;
         s3_mh_ff  <= s3_mh_in;
      end
   end

   // stage 4: step numerator and corrected second moment
   logic                 s4_vld_ff;
   logic signed [DW-1:0] s4_p_ff, s4_nm_ff, s4_np_ff;
   logic [SW-1:0]        s4_ns_ff;
   sval_type             s4_num_ff, s4_vh_ff, s4_num_in, s4_vh_in;
   logic signed [DW-1:0] mh_s;

   always_comb begin
      mh_s = sat_s(s3_mh_ff);
      if (mode_ff == MODE_ADAM) begin
         s4_num_in = fx_mul(MAG_W'(lr_ff), mag32(mh_s), mh_s[DW-1]);
         s4_vh_in  = fx_mul(MAG_W'(s3_ns_ff), DW'(c2_ff), 1'b0);
      end else begin
         s4_num_in = SV_W'(s3_num_ff);
         s4_vh_in  = $signed(SV_W'(s3_ns_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_p_ff   <= s3_p_ff;
         s4_nm_ff  <= s3_nm_ff;
         s4_np_ff  <= s3_np_ff;
         s4_ns_ff  <= s3_ns_ff;
         s4_num_ff <= s4_num_in;
         s4_vh_ff  <= s4_vh_in;
      end
   end

   // stage 5: saturate numerator and root operand
   logic                 s5_vld_ff;
   logic signed [DW-1:0] s5_p_ff, s5_nm_ff, s5_np_ff, s5_num_ff;
   logic [SW-1:0]        s5_ns_ff, s5_vh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (adv) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_p_ff   <= s4_p_ff;
         s5_nm_ff  <= s4_nm_ff;
         s5_np_ff  <= s4_np_ff;
         s5_ns_ff  <= s4_ns_ff;
         s5_num_ff <= sat_s(s4_num_ff);
         s5_vh_ff  <= sat_u(s4_vh_ff);
      end
   end

   // square root
   logic                   rt_vld;
   logic [ROOT_W-1:0]      rt_root;
   logic [ROOT_SIDE_W-1:0] rt_side;
   logic signed [DW-1:0]   rt_p, rt_nm, rt_np, rt_num;
   logic [SW-1:0]          rt_ns;

   opu_root #(
      .SIDE_W (ROOT_SIDE_W)
   ) u_root (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (s5_vld_ff),
      .in_value (s5_vh_ff),
      .in_side  ({s5_p_ff, s5_nm_ff, s5_ns_ff, s5_np_ff, s5_num_ff}),
      .out_vld  (rt_vld),
      .out_root (rt_root),
      .out_side (rt_side)
   );

   assign {rt_p, rt_nm, rt_ns, rt_np, rt_num} = rt_side;

   // divide
   logic                  dv_vld;
   logic [QUO_W-1:0]      dv_quo;
   logic [DIV_SIDE_W-1:0] dv_side;
   logic signed [DW-1:0]  dv_p, dv_nm, dv_np;
   logic [SW-1:0]         dv_ns;
   logic                  dv_neg;
   logic [DEN_W-1:0]      den;

   assign den = DEN_W'(rt_root) + DEN_W'(eps_ff);

   opu_div #(
      .SIDE_W (DIV_SIDE_W)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .in_vld      (rt_vld),
      .in_dividend ({mag32(rt_num), {FB{1'b0}}}),
      .in_divisor  (den),
      .in_side     ({rt_p, rt_nm, rt_ns, rt_np, rt_num[DW-1]}),
      .out_vld     (dv_vld),
      .out_quo     (dv_quo),
      .out_side    (dv_side)
   );

   assign {dv_p, dv_nm, dv_ns, dv_np, dv_neg} = dv_side;

   // final subtract and output register
   logic [QC_W-1:0]      qc;
   sval_type             delta;
   logic signed [DW-1:0] np_div, np_out;

   always_comb begin
      qc     = (|dv_quo[QUO_W-1:QC_W-1]) ? QC_MAX : dv_quo[QC_W-1:0];
      delta  = dv_neg ? -$signed(SV_W'(qc)) : $signed(SV_W'(qc));
      np_div = sat_s(SV_W'(dv_p) - delta);
      if (err || (mode_ff == MODE_SGD) || (mode_ff == MODE_MOMENTUM)) begin
         np_out = dv_np;
      end else begin
         np_out = np_div;
      end
   end

   logic                 rsp_valid_ff;
   logic signed [DW-1:0] rsp_np_ff, rsp_nm_ff;
   logic [SW-1:0]        rsp_ns_ff;
   logic                 rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_np_ff  <= np_out;
         rsp_nm_ff  <= dv_nm;
         rsp_ns_ff  <= dv_ns;
         rsp_err_ff <= err;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_new_param         = rsp_np_ff;
   assign rsp_new_first_moment  = rsp_nm_ff;
   assign rsp_new_second_moment = rsp_ns_ff;
   assign rsp_coef_error        = rsp_err_ff;

endmodule

>>> hdl/opu_chk.sv
module opu_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_new_param,
   input logic [31:0] rsp_new_first_moment,
   input logic [30:0] rsp_new_second_moment,
   input logic        rsp_coef_error
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_new_param)
         && $stable(rsp_new_first_moment) && $stable(rsp_new_second_moment)
         && $stable(rsp_coef_error)))
      else $error("stalled response transaction changed");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken while response is blocked");

   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

endmodule

bind optimizer_param_update opu_chk u_opu_chk (.*);
